>>> hdl/slcd_pkg.sv
package slcd_pkg;

  // Fixed header size added to the body length carried in the frame.
  localparam int HEADER_BYTES = 28;

  localparam int CNT_W = 17;
  localparam int CRC_W = 32;
  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;

  // Header offsets of the captured fields.
  localparam logic [CNT_W-1:0] OFF_SYNC_LAST = 17'd2;
  localparam logic [CNT_W-1:0] OFF_FIRST_BODY = 17'd3;
  localparam logic [CNT_W-1:0] OFF_TYPE_LO = 17'd4;
  localparam logic [CNT_W-1:0] OFF_TYPE_HI = 17'd5;
  localparam logic [CNT_W-1:0] OFF_LEN_LO = 17'd8;
  localparam logic [CNT_W-1:0] OFF_LEN_HI = 17'd9;
  localparam logic [CNT_W-1:0] OFF_CRC_FORCED = 17'd10;
  localparam logic [CNT_W-1:0] OFF_WEEK_LO = 17'd14;
  localparam logic [CNT_W-1:0] OFF_WEEK_HI = 17'd15;
  localparam logic [CNT_W-1:0] OFF_TOW_B0 = 17'd16;
  localparam logic [CNT_W-1:0] OFF_TOW_B1 = 17'd17;
  localparam logic [CNT_W-1:0] OFF_TOW_B2 = 17'd18;
  localparam logic [CNT_W-1:0] OFF_TOW_B3 = 17'd19;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAX_LEN = 2'd0;
  localparam logic [1:0] CFG_SYNC_FIRST = 2'd1;
  localparam logic [1:0] CFG_SYNC_SECOND = 2'd2;
  localparam logic [1:0] CFG_SYNC_THIRD = 2'd3;

  // Configuration reset values.
  localparam logic [CNT_W-1:0] MAX_LEN_RST = 17'd16380;
  localparam logic [7:0] SYNC_FIRST_RST = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h44;
  localparam logic [7:0] SYNC_THIRD_RST = 8'h12;

  // Per-byte event codes.
  typedef enum logic [2:0] {
    EV_HUNT      = 3'd0,
    EV_IN_FRAME  = 3'd1,
    EV_GOOD      = 3'd2,
    EV_CRC_ERR   = 3'd3,
    EV_LEN_ERR   = 3'd4,
    EV_WEEK_ZERO = 3'd5
  } evt_t;

  // Configuration write port, grouped.
  typedef struct packed {
    logic             we;
    logic [1:0]       index;
    logic [CNT_W-1:0] data;
  } cfg_wr_t;

  // One result item.
  typedef struct packed {
    evt_t             ev;
    logic [7:0]       echo_byte;
    logic [CNT_W-1:0] byte_offset;
    logic [15:0]      msg_type;
    logic [CNT_W-1:0] msg_length;
    logic [15:0]      week_num;
    logic [31:0]      tow_ms;
  } result_t;

  // Reflected CRC-32 update by one byte; flattens to an XOR network.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c_in,
                                               input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // CRC over the three sync bytes from a zero start. Since the start is zero
  // the result is a fixed linear map of the 24 sync bits.
  function automatic logic [CRC_W-1:0] crc_sync(input logic [7:0] a,
                                               input logic [7:0] b,
                                               input logic [7:0] c);
    return crc_byte(crc_byte(crc_byte('0, a), b), c);
  endfunction

endpackage

>>> hdl/sync_length_crc32_deframer_top.sv
// Byte-serial deframer for frames that open with a three-byte sync pattern,
// carry a little-endian body length at header bytes 8 and 9, and end with a
// little-endian reflected CRC-32 word.
// Bytes enter on the s_ stream channel, one per transaction. Every byte gives
// exactly one result on the m_ channel: the event code in m_tuser, and in
// m_tdata the byte itself, its frame offset and the header fields captured
// so far. A frame verdict (good, CRC error, week zero) comes with the last
// CRC byte; a length error comes with header byte 9. The block then hunts.
// The result is valid in the cycle after the input transaction; throughput is
// one byte per cycle while m_tready stays high, set by the single result
// register behind the CRC and header capture logic. On a receiver stall the
// result register holds; s_tready drops only while it is full and not taken.
// The configuration port writes one register per cycle with cfg_we high:
// index 0 maximum frame length, 1 to 3 the sync bytes in order.
// Reset clears the frame state to hunting, empties the result register and
// loads the default sync pattern and maximum length.
module sync_length_crc32_deframer_top
  import slcd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  // Input byte stream.
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // [7:0] rx_byte
  // Result stream.
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [111:0]  m_tdata,   // [7:0] echo_byte, [24:8] byte_offset, [40:25] msg_type,
                                   // [57:41] msg_length, [73:58] week_num,
                                   // [105:74] tow_ms, [111:106] zero
  output logic [2:0]    m_tuser,   // [2:0] event_res
  // Configuration write port.
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [16:0]   cfg_data
);

  cfg_wr_t cfg;
  result_t core_res;
  result_t out_res;
  logic    fire;

  assign cfg  = '{we: cfg_we, index: cfg_index, data: cfg_data};
  assign fire = s_tvalid && s_tready;

  slcd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .fire    (fire),
    .rx_byte (s_tdata),
    .res     (core_res)
  );

  slcd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_res    (core_res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  // Pack the result fields onto the stream.
  assign m_tuser = out_res.ev;
  assign m_tdata = {6'd0, out_res.tow_ms, out_res.week_num, out_res.msg_length,
                    out_res.msg_type, out_res.byte_offset, out_res.echo_byte};

`ifndef SYNTHESIS
  // An accepted byte always leaves a result behind it.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted byte produced no result");

  // Hunting results carry no frame information.
  a_hunt_is_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.ev == EV_HUNT |->
      out_res.byte_offset == '0 && out_res.msg_length == '0 && out_res.tow_ms == '0)
    else $error("hunting result carries frame fields");

  // A length error is reported only on the high length byte.
  a_len_err_offset: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.ev == EV_LEN_ERR |-> out_res.byte_offset == OFF_LEN_HI)
    else $error("length error at wrong offset");

  // A CRC verdict is given on the last CRC byte of the frame.
  a_verdict_offset: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_res.ev == EV_GOOD || out_res.ev == EV_CRC_ERR ||
                 out_res.ev == EV_WEEK_ZERO) |->
      {1'b0, out_res.byte_offset} == {1'b0, out_res.msg_length} + 18'd3)
    else $error("frame verdict at wrong offset");
`endif

endmodule

>>> hdl/slcd_core.sv
module slcd_core
  import slcd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_wr_t cfg,
  input  logic    fire,
  input  logic [7:0] rx_byte,
  output result_t res
);

  // Configuration registers.
  logic [CNT_W-1:0] max_len;
  logic [7:0] sync_first;
  logic [7:0] sync_second;
  logic [7:0] sync_third;

  // Deframer state.
  logic [15:0]      sync_window, sync_window_next;
  logic [CNT_W-1:0] frame_count, frame_count_next;
  logic [CNT_W-1:0] frame_length, frame_length_next;
  logic [CRC_W-1:0] running_crc, running_crc_next;
  logic [CRC_W-1:0] received_crc, received_crc_next;
  logic [15:0]      type_reg, type_reg_next;
  logic [15:0]      week_reg, week_reg_next;
  logic [31:0]      tow_reg, tow_reg_next;

  logic [CNT_W-1:0] off;
  logic [1:0]       crc_lane;
  logic             crc_en;
  logic             at_end;

  // Configuration writes take effect at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len     <= MAX_LEN_RST;
      sync_first  <= SYNC_FIRST_RST;
      sync_second <= SYNC_SECOND_RST;
      sync_third  <= SYNC_THIRD_RST;
    end else if (cfg.we) begin
      case (cfg.index)
        CFG_MAX_LEN:     max_len     <= cfg.data;
        CFG_SYNC_FIRST:  sync_first  <= cfg.data[7:0];
        CFG_SYNC_SECOND: sync_second <= cfg.data[7:0];
        CFG_SYNC_THIRD:  sync_third  <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // Next state and result for the byte on the input.
  always_comb begin
    sync_window_next  = sync_window;
    frame_count_next  = frame_count;
    frame_length_next = frame_length;
    running_crc_next  = running_crc;
    received_crc_next = received_crc;
    type_reg_next     = type_reg;
    week_reg_next     = week_reg;
    tow_reg_next      = tow_reg;
    off               = frame_count;
    crc_lane          = 2'(frame_count - frame_length);
    crc_en            = (frame_count < OFF_CRC_FORCED) || (frame_count < frame_length);
    at_end            = 1'b0;

    res.ev          = EV_HUNT;
    res.echo_byte   = rx_byte;
    res.byte_offset = '0;
    res.msg_type    = '0;
    res.msg_length  = '0;
    res.week_num    = '0;
    res.tow_ms      = '0;

    if (frame_count == '0) begin
      // Hunting: slide the window and look for the sync pattern.
      sync_window_next = {sync_window[7:0], rx_byte};
      if (sync_window[15:8] == sync_first && sync_window[7:0] == sync_second &&
          rx_byte == sync_third) begin
        frame_count_next  = OFF_FIRST_BODY;
        frame_length_next = '0;
        received_crc_next = '0;
        type_reg_next     = '0;
        week_reg_next     = '0;
        tow_reg_next      = '0;
        running_crc_next  = crc_sync(sync_window[15:8], sync_window[7:0], rx_byte);
        res.ev            = EV_IN_FRAME;
        res.byte_offset   = OFF_SYNC_LAST;
      end
    end else begin
      frame_count_next = frame_count + 17'd1;

      // Bytes before the CRC feed it; the four trailing bytes form the received word.
      if (crc_en) begin
        running_crc_next = crc_byte(running_crc, rx_byte);
      end else begin
        received_crc_next = received_crc | ({24'd0, rx_byte} << {crc_lane, 3'd0});
      end

      // Header field capture.
      case (off)
        OFF_TYPE_LO: type_reg_next = {type_reg[15:8], rx_byte};
        OFF_TYPE_HI: type_reg_next = {rx_byte, type_reg[7:0]};
        OFF_LEN_LO:  frame_length_next = {9'd0, rx_byte};
        OFF_LEN_HI:  frame_length_next = {1'b0, rx_byte, frame_length[7:0]} +
                                         17'(HEADER_BYTES);
        OFF_WEEK_LO: week_reg_next = {week_reg[15:8], rx_byte};
        OFF_WEEK_HI: week_reg_next = {rx_byte, week_reg[7:0]};
        OFF_TOW_B0:  tow_reg_next = {tow_reg[31:8], rx_byte};
        OFF_TOW_B1:  tow_reg_next = {tow_reg[31:16], rx_byte, tow_reg[7:0]};
        OFF_TOW_B2:  tow_reg_next = {tow_reg[31:24], rx_byte, tow_reg[15:0]};
        OFF_TOW_B3:  tow_reg_next = {rx_byte, tow_reg[23:0]};
        default: ;
      endcase

      // The last CRC byte sits three bytes past the end of the length.
      at_end = (off >= OFF_LEN_HI) &&
               ({1'b0, off} + 18'd1 >= {1'b0, frame_length_next} + 18'd4);

      res.ev = EV_IN_FRAME;
      if (off == OFF_LEN_HI && frame_length_next > max_len) begin
        res.ev           = EV_LEN_ERR;
        frame_count_next = '0;
      end else if (at_end) begin
        if (running_crc_next != received_crc_next) begin
          res.ev = EV_CRC_ERR;
        end else if (week_reg_next == '0) begin
          res.ev = EV_WEEK_ZERO;
        end else begin
          res.ev = EV_GOOD;
        end
        frame_count_next = '0;
      end

      res.byte_offset = off;
      res.msg_type    = type_reg_next;
      res.msg_length  = (off >= OFF_LEN_HI) ? frame_length_next : '0;
      res.week_num    = week_reg_next;
      res.tow_ms      = tow_reg_next;
    end
  end

  // State update on every accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_window  <= '0;
      frame_count  <= '0;
      frame_length <= '0;
      running_crc  <= '0;
      received_crc <= '0;
      type_reg     <= '0;
      week_reg     <= '0;
      tow_reg      <= '0;
    end else if (fire) begin
      sync_window  <= sync_window_next;
      frame_count  <= frame_count_next;
      frame_length <= frame_length_next;
      running_crc  <= running_crc_next;
      received_crc <= received_crc_next;
      type_reg     <= type_reg_next;
      week_reg     <= week_reg_next;
      tow_reg      <= tow_reg_next;
    end
  end

endmodule

>>> hdl/slcd_out_reg.sv
module slcd_out_reg
  import slcd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_res,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  // The register takes a new result whenever it is empty or being drained.
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_res <= in_res;
    end
  end

endmodule
